/* src/sensor_pulse_qualifier_assert.svh */
`ifndef SENSOR_PULSE_QUALIFIER_ASSERT_SVH
`define SENSOR_PULSE_QUALIFIER_ASSERT_SVH

// Concurrent checks, clocked on clk, disabled while rst is high.
`ifndef ASSERT_OFF
`define SPQ_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("check failed: cond");
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: ante then cons");
`else
`define SPQ_ASSERT(label, clk, rst, cond)
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/spq_pkg.sv */
package spq_pkg;

   localparam int CNT_W = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_TICKS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_DIVIDE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_CAP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BATT_DEBOUNCE = 3'd5;

   localparam logic [CNT_W-1:0] RST_RELEASE_TICKS = 8'd200;
   localparam logic [CNT_W-1:0] RST_SAMPLE_DIVIDE = 8'd2;
   localparam logic [CNT_W-1:0] RST_PULSE_CAP = 8'd50;
   localparam logic [CNT_W-1:0] RST_WINDOW_TICKS = 8'd200;
   localparam logic [CNT_W-1:0] RST_PULSE_THRESHOLD = 8'd20;
   localparam logic [CNT_W-1:0] RST_BATT_DEBOUNCE = 8'd1;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_OPEN = 2'd1;
   localparam logic [1:0] STATUS_CLOSED = 2'd2;

   localparam logic [1:0] BATT_NONE = 2'd0;
   localparam logic [1:0] BATT_ON = 2'd1;
   localparam logic [1:0] BATT_OFF = 2'd2;

   typedef struct packed {
      logic             advance;
      logic             batt_level;
      logic [CNT_W-1:0] debounce;
   } batt_ctl_type;

endpackage

/* src/sensor_pulse_qualifier.sv */
// channel  | valid      | stall      | payload
// ---------+------------+------------+--------------------------------------------
// req      | req_valid  | req_stall  | sensor_level, batt_level, lockout_clear
// rsp      | rsp_valid  | rsp_stall  | sensor_status, sleep_ok, lockout, wake_enable,
//          |            |            | batt_state
// csr      | csr_write  | -          | csr_index, csr_wdata
//
// One item per cycle while req_stall is low; each item's result is registered on acceptance.
// The state update is a single pass of 8-bit counter compares between state registers.
// Sync reset loads register defaults, clears counters and flags, sets the off latch.
// req_stall follows rsp_stall only while a result is held; otherwise items flow freely.
`include "sensor_pulse_qualifier_assert.svh"

module sensor_pulse_qualifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_sensor_level,
   input  logic                           req_batt_level,
   input  logic                           req_lockout_clear,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_sensor_status,
   output logic                           rsp_sleep_ok,
   output logic                           rsp_lockout,
   output logic                           rsp_wake_enable,
   output logic [1:0]                     rsp_batt_state,
   input  logic                           csr_write,
   input  logic [spq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spq_pkg::CNT_W-1:0]      csr_wdata
);
   import spq_pkg::*;

   logic [CNT_W-1:0] release_ticks_ff, sample_divide_ff, pulse_cap_ff;
   logic [CNT_W-1:0] window_ticks_ff, pulse_threshold_ff, batt_debounce_ff;

   logic [CNT_W-1:0] release_count_ff, release_count_in;
   logic [CNT_W-1:0] active_count_ff, active_count_in;
   logic [CNT_W-1:0] window_count_ff, window_count_in;
   logic [CNT_W-1:0] pulse_count_ff, pulse_count_in;
   logic             released_ff, released_in;
   logic             pressed_ff, pressed_in;
   logic             window_active_ff, window_active_in;
   logic             lockout_ff, lockout_in;
   logic [1:0]       status_ff, status_in;
   logic             wake_ff, wake_in;
   logic             sleep_ff, sleep_in;
   logic             rsp_valid_ff;
   logic             accept;
   batt_ctl_type     batt_ctl;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         release_ticks_ff <= RST_RELEASE_TICKS;
         sample_divide_ff <= RST_SAMPLE_DIVIDE;
         pulse_cap_ff <= RST_PULSE_CAP;
         window_ticks_ff <= RST_WINDOW_TICKS;
         pulse_threshold_ff <= RST_PULSE_THRESHOLD;
         batt_debounce_ff <= RST_BATT_DEBOUNCE;
      end else if (csr_write) begin
         case (csr_index)
            REG_RELEASE_TICKS: release_ticks_ff <= csr_wdata;
            REG_SAMPLE_DIVIDE: sample_divide_ff <= csr_wdata;
            REG_PULSE_CAP: pulse_cap_ff <= csr_wdata;
            REG_WINDOW_TICKS: window_ticks_ff <= csr_wdata;
            REG_PULSE_THRESHOLD: pulse_threshold_ff <= csr_wdata;
            REG_BATT_DEBOUNCE: batt_debounce_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      release_count_in = release_count_ff;
      active_count_in = active_count_ff;
      window_count_in = window_count_ff;
      pulse_count_in = pulse_count_ff;
      released_in = released_ff;
      pressed_in = pressed_ff;
      window_active_in = window_active_ff;
      lockout_in = req_lockout_clear ? 1'b0 : lockout_ff;
      status_in = status_ff;
      wake_in = wake_ff;
      sleep_in = sleep_ff;

      if (!req_sensor_level) begin
         active_count_in = '0;
         if (!released_ff) begin
            sleep_in = 1'b0;
            if (release_count_ff != CNT_MAX) begin
               release_count_in = release_count_ff + CNT_W'(1);
            end
            if (release_count_in >= release_ticks_ff) begin
               status_in = STATUS_OPEN;
               released_in = 1'b1;
               lockout_in = 1'b1;
               wake_in = 1'b1;
               pressed_in = 1'b0;
            end
         end else begin
            sleep_in = 1'b1;
         end
      end else begin
         release_count_in = '0;
         if (!pressed_ff) begin
            sleep_in = 1'b0;
            window_active_in = 1'b1;
            active_count_in = active_count_ff + CNT_W'(1);
            if (active_count_in > sample_divide_ff) begin
               active_count_in = '0;
               if (pulse_count_ff < pulse_cap_ff) begin
                  pulse_count_in = pulse_count_ff + CNT_W'(1);
               end
            end
         end else begin
            sleep_in = 1'b1;
         end
      end

      if (window_active_in) begin
         if (window_count_ff != CNT_MAX) begin
            window_count_in = window_count_ff + CNT_W'(1);
         end
         if (window_count_in >= window_ticks_ff) begin
            window_count_in = '0;
            window_active_in = 1'b0;
            if (pulse_count_in >= pulse_threshold_ff) begin
               pulse_count_in = '0;
               if (!lockout_in) begin
                  status_in = STATUS_CLOSED;
                  pressed_in = 1'b1;
                  released_in = 1'b0;
               end
            end
         end
      end else begin
         window_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_count_ff <= '0;
         active_count_ff <= '0;
         window_count_ff <= '0;
         pulse_count_ff <= '0;
         released_ff <= 1'b0;
         pressed_ff <= 1'b0;
         window_active_ff <= 1'b0;
         lockout_ff <= 1'b0;
         status_ff <= STATUS_NONE;
         wake_ff <= 1'b0;
         sleep_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            release_count_ff <= release_count_in;
            active_count_ff <= active_count_in;
            window_count_ff <= window_count_in;
            pulse_count_ff <= pulse_count_in;
            released_ff <= released_in;
            pressed_ff <= pressed_in;
            window_active_ff <= window_active_in;
            lockout_ff <= lockout_in;
            status_ff <= status_in;
            wake_ff <= wake_in;
            sleep_ff <= sleep_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign batt_ctl.advance = accept;
   assign batt_ctl.batt_level = req_batt_level;
   assign batt_ctl.debounce = batt_debounce_ff;

   spq_batt_debounce u_batt (
      .clock      (clock),
      .reset      (reset),
      .ctl        (batt_ctl),
      .batt_state (rsp_batt_state)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sensor_status = status_ff;
   assign rsp_sleep_ok = sleep_ff;
   assign rsp_lockout = lockout_ff;
   assign rsp_wake_enable = wake_ff;

   `SPQ_ASSERT(a_latch_excl, clock, reset, !(released_ff && pressed_ff))
   `SPQ_ASSERT(a_window_idle, clock, reset, window_active_ff || (window_count_ff == '0))
   `SPQ_ASSERT_NEXT(a_wake_sticky, clock, reset, wake_ff, wake_ff)
   `SPQ_ASSERT(a_lock_on_open, clock, reset, !$rose(lockout_ff) || (status_ff == STATUS_OPEN))
   `SPQ_ASSERT_NEXT(a_accept_result, clock, reset, accept, rsp_valid_ff)

endmodule

/* src/spq_batt_debounce.sv */
`include "sensor_pulse_qualifier_assert.svh"

module spq_batt_debounce (
   input  logic                clock,
   input  logic                reset,
   input  spq_pkg::batt_ctl_type ctl,
   output logic [1:0]          batt_state
);
   import spq_pkg::*;

   logic [CNT_W-1:0] on_count_ff, on_count_in;
   logic [CNT_W-1:0] off_count_ff, off_count_in;
   logic             on_latch_ff, on_latch_in;
   logic             off_latch_ff, off_latch_in;
   logic [1:0]       batt_reg_ff, batt_reg_in;

   always_comb begin
      on_count_in = on_count_ff;
      off_count_in = off_count_ff;
      on_latch_in = on_latch_ff;
      off_latch_in = off_latch_ff;
      batt_reg_in = batt_reg_ff;
      if (ctl.batt_level) begin
         off_count_in = '0;
         off_latch_in = 1'b0;
         on_count_in = on_count_ff + CNT_W'(1);
         if (on_count_in > ctl.debounce) begin
            on_count_in = '0;
            if (!on_latch_ff) begin
               on_latch_in = 1'b1;
               batt_reg_in = BATT_ON;
            end
         end
      end else begin
         on_count_in = '0;
         on_latch_in = 1'b0;
         off_count_in = off_count_ff + CNT_W'(1);
         if (off_count_in > ctl.debounce) begin
            off_count_in = '0;
            if (!off_latch_ff) begin
               off_latch_in = 1'b1;
               batt_reg_in = BATT_OFF;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_count_ff <= '0;
         off_count_ff <= '0;
         on_latch_ff <= 1'b0;
         off_latch_ff <= 1'b1;
         batt_reg_ff <= BATT_NONE;
      end else if (ctl.advance) begin
         on_count_ff <= on_count_in;
         off_count_ff <= off_count_in;
         on_latch_ff <= on_latch_in;
         off_latch_ff <= off_latch_in;
         batt_reg_ff <= batt_reg_in;
      end
   end

   assign batt_state = batt_reg_ff;

   `SPQ_ASSERT(a_latch_excl, clock, reset, !(on_latch_ff && off_latch_ff))
   `SPQ_ASSERT_NEXT(a_hold_idle, clock, reset, !ctl.advance, $stable(batt_reg_ff))
   `SPQ_ASSERT_NEXT(a_on_needs_high, clock, reset, ctl.advance && !ctl.batt_level,
                    !on_latch_ff)

endmodule
